>>> sv/gif_frame_pixel_compositor_assert.svh
// ----------------------------------------------------------------------------
// gif frame pixel compositor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GIF_FRAME_PIXEL_COMPOSITOR_ASSERT_SVH
`define GIF_FRAME_PIXEL_COMPOSITOR_ASSERT_SVH

// same-cycle implication
`define GFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfc same-cycle check failed");

// next-cycle implication
`define GFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfc next-cycle check failed");

`endif

>>> sv/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// shared types and constants of the gif frame pixel compositor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gfc_pkg;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_FRAME_LEFT       = 3'd0;
    localparam cfg_idx_t REG_FRAME_TOP        = 3'd1;
    localparam cfg_idx_t REG_FRAME_WIDTH      = 3'd2;
    localparam cfg_idx_t REG_FRAME_HEIGHT     = 3'd3;
    localparam cfg_idx_t REG_INTERLACED       = 3'd4;
    localparam cfg_idx_t REG_TRANSPARENT_MODE = 3'd5;
    localparam cfg_idx_t REG_TRANSPARENT_CODE = 3'd6;
    localparam cfg_idx_t REG_BACKGROUND_SLOT  = 3'd7;

    typedef logic [1:0] trans_mode_t;

    localparam trans_mode_t TM_NONE       = 2'd0;
    localparam trans_mode_t TM_BACKGROUND = 2'd1;

    // item kind carried on tuser
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam int CFG_DATA_BITS = 16;
    localparam int SLOT_BITS     = 8;
    localparam int RGB_BITS      = 24;
    localparam int SCREEN_BITS   = 17;
    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 72;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // interlace row step and start row per pass
    localparam logic [3:0] PASS_STEP  [4] = '{4'd8, 4'd8, 4'd4, 4'd2};
    localparam logic [3:0] PASS_START [4] = '{4'd0, 4'd4, 4'd2, 4'd1};

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_slot;
        logic [RGB_BITS-1:0]  wr_rgb;
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_slot;
    } pal_req_t;

    typedef struct packed {
        logic step;
        logic first;
        logic interlaced;
    } walk_ctl_t;

endpackage

>>> sv/gfc_palette.sv
// ----------------------------------------------------------------------------
// gfc_palette
// colour palette memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfc_palette #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gfc_pkg::pal_req_t                  req,
    output logic [gfc_pkg::RGB_BITS-1:0]       rd_rgb
);
    import gfc_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [RGB_BITS-1:0] mem [PALETTE_ENTRIES];
    logic [RGB_BITS-1:0] rd_data_reg;
    logic                rd_ok_reg;
    logic                wr_ok;
    logic                rd_ok;

    assign wr_ok = ({1'b0, req.wr_slot} < (SLOT_BITS+1)'(PALETTE_ENTRIES));
    assign rd_ok = ({1'b0, req.rd_slot} < (SLOT_BITS+1)'(PALETTE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_ok)
        begin
            mem[req.wr_slot[AW-1:0]] <= req.wr_rgb;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_slot[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else if (req.rd_en)
        begin
            rd_ok_reg <= rd_ok;
        end
    end

    // slot beyond the palette reads as black
    assign rd_rgb = rd_ok_reg ? rd_data_reg : '0;

endmodule

>>> sv/gfc_walk.sv
// ----------------------------------------------------------------------------
// gfc_walk
// column, row and interlace pass counters of the frame walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gfc_walk #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gfc_pkg::walk_ctl_t    ctl,
    input  logic [COORD_BITS-1:0] frame_width,
    input  logic [COORD_BITS-1:0] frame_height,
    output logic [COORD_BITS-1:0] column,
    output logic [COORD_BITS-1:0] row
);
    import gfc_pkg::*;

    localparam int CW = COORD_BITS + 1;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [1:0]            pass_reg, pass_next;

    logic [1:0]            pass_cur;
    logic [CW-1:0]         col_inc;
    logic [CW-1:0]         row_inc;
    logic [CW-1:0]         row_il;
    logic [CW-1:0]         height_w;
    logic                  col_wrap;
    logic                  c1, c2, c3;
    logic [COORD_BITS-1:0] row_adv;
    logic [1:0]            pass_adv;

    assign column   = ctl.first ? '0 : col_reg;
    assign row      = ctl.first ? '0 : row_reg;
    assign pass_cur = ctl.first ? 2'd0 : pass_reg;

    assign height_w = {1'b0, frame_height};
    assign col_inc  = {1'b0, column} + CW'(1);
    assign col_wrap = (col_inc >= {1'b0, frame_width});
    assign row_inc  = {1'b0, row} + CW'(1);
    assign row_il   = {1'b0, row} + CW'(PASS_STEP[pass_cur]);

    assign c1 = (CW'(PASS_START[1]) < height_w);
    assign c2 = (CW'(PASS_START[2]) < height_w);
    assign c3 = (CW'(PASS_START[3]) < height_w);

    always_comb
    begin
        row_adv  = '0;
        pass_adv = 2'd0;
        if (!ctl.interlaced)
        begin
            pass_adv = pass_cur;
            row_adv  = (row_inc >= height_w) ? '0 : row_inc[COORD_BITS-1:0];
        end
        else if (row_il < height_w)
        begin
            pass_adv = pass_cur;
            row_adv  = row_il[COORD_BITS-1:0];
        end
        else
        begin
            // first later pass whose start row lies inside the frame
            case (pass_cur)
                2'd0:
                begin
                    if (c1)
                    begin
                        pass_adv = 2'd1;
                        row_adv  = COORD_BITS'(PASS_START[1]);
                    end
                    else if (c2)
                    begin
                        pass_adv = 2'd2;
                        row_adv  = COORD_BITS'(PASS_START[2]);
                    end
                    else if (c3)
                    begin
                        pass_adv = 2'd3;
                        row_adv  = COORD_BITS'(PASS_START[3]);
                    end
                end
                2'd1:
                begin
                    if (c2)
                    begin
                        pass_adv = 2'd2;
                        row_adv  = COORD_BITS'(PASS_START[2]);
                    end
                    else if (c3)
                    begin
                        pass_adv = 2'd3;
                        row_adv  = COORD_BITS'(PASS_START[3]);
                    end
                end
                2'd2:
                begin
                    if (c3)
                    begin
                        pass_adv = 2'd3;
                        row_adv  = COORD_BITS'(PASS_START[3]);
                    end
                end
                default:
                begin
                    pass_adv = 2'd0;
                    row_adv  = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pass_next = pass_reg;
        if (ctl.step)
        begin
            if (col_wrap)
            begin
                col_next  = '0;
                row_next  = row_adv;
                pass_next = pass_adv;
            end
            else
            begin
                col_next  = col_inc[COORD_BITS-1:0];
                row_next  = row;
                pass_next = pass_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pass_reg <= 2'd0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pass_reg <= pass_next;
        end
    end

endmodule

>>> sv/gif_frame_pixel_compositor.sv
// an accepted pixel code passes stage one with its palette read, then the output register
// one item per cycle while m_tready is high; a stall with stage one full blocks input
// registered palette read plus output register: a result is read out after both
// palette write produces no item; a code read right after its write sees it
// reset clears counters, valid flags, config (size to 1); palette undefined until written
// ----------------------------------------------------------------------------
// gif_frame_pixel_compositor
// palette lookup and frame walk for gif pixel codes, raster or interlaced
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gif_frame_pixel_compositor #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int COORD_BITS      = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // palette_slot[7:0], palette_rgb[31:8], pixel_code[39:32], first_pixel[40]
    input  logic [gfc_pkg::IN_DATA_BITS-1:0]       s_tdata,
    // kind[0]
    input  logic                                   s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // screen_row[16:0], screen_column[33:17], argb_word[65:34]
    output logic [gfc_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  gfc_pkg::cfg_idx_t                      cfg_index,
    input  logic [gfc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready
);
    import gfc_pkg::*;

    logic [COORD_BITS-1:0] frame_left_reg;
    logic [COORD_BITS-1:0] frame_top_reg;
    logic [COORD_BITS-1:0] frame_width_reg;
    logic [COORD_BITS-1:0] frame_height_reg;
    logic                  interlaced_reg;
    trans_mode_t           trans_mode_reg;
    logic [SLOT_BITS-1:0]  trans_code_reg;
    logic [SLOT_BITS-1:0]  bg_slot_reg;

    logic [SLOT_BITS-1:0]  in_slot;
    logic [RGB_BITS-1:0]   in_rgb;
    logic [SLOT_BITS-1:0]  in_code;
    logic                  in_first;

    logic                  in_acc;
    logic                  pix_acc;
    logic                  code_match;
    logic                  use_bg;
    logic                  skip;
    logic                  out_ld;

    logic [COORD_BITS-1:0] cfg_coord;
    logic [COORD_BITS-1:0] cfg_size;

    pal_req_t              pal_req;
    logic [RGB_BITS-1:0]   pal_rgb;
    walk_ctl_t             walk_ctl;
    logic [COORD_BITS-1:0] walk_col;
    logic [COORD_BITS-1:0] walk_row;

    logic                   st1_valid_reg, st1_valid_next;
    logic [SCREEN_BITS-1:0] st1_row_reg;
    logic [SCREEN_BITS-1:0] st1_col_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_BITS-1:0] m_data_reg;
    logic [31:0]            argb;

    assign in_slot  = s_tdata[7:0];
    assign in_rgb   = s_tdata[31:8];
    assign in_code  = s_tdata[39:32];
    assign in_first = s_tdata[40];

    assign cfg_ready = 1'b1;
    assign cfg_coord = cfg_data[COORD_BITS-1:0];
    assign cfg_size  = (cfg_coord == '0) ? COORD_BITS'(1) : cfg_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_left_reg   <= '0;
            frame_top_reg    <= '0;
            frame_width_reg  <= COORD_BITS'(1);
            frame_height_reg <= COORD_BITS'(1);
            interlaced_reg   <= 1'b0;
            trans_mode_reg   <= TM_NONE;
            trans_code_reg   <= '0;
            bg_slot_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_LEFT:       frame_left_reg   <= cfg_coord;
                REG_FRAME_TOP:        frame_top_reg    <= cfg_coord;
                REG_FRAME_WIDTH:      frame_width_reg  <= cfg_size;
                REG_FRAME_HEIGHT:     frame_height_reg <= cfg_size;
                REG_INTERLACED:       interlaced_reg   <= cfg_data[0];
                REG_TRANSPARENT_MODE: trans_mode_reg   <= cfg_data[1:0];
                REG_TRANSPARENT_CODE: trans_code_reg   <= cfg_data[7:0];
                REG_BACKGROUND_SLOT:  bg_slot_reg      <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    assign out_ld   = !m_valid_reg || m_tready;
    assign s_tready = !st1_valid_reg || out_ld;
    assign in_acc   = s_tvalid && s_tready;
    assign pix_acc  = in_acc && (s_tuser == KIND_PIXEL);

    assign code_match = (trans_mode_reg != TM_NONE) && (in_code == trans_code_reg);
    assign use_bg     = code_match && (trans_mode_reg == TM_BACKGROUND);
    assign skip       = code_match && !use_bg;

    assign pal_req.wr_en   = in_acc && (s_tuser == KIND_PALETTE);
    assign pal_req.wr_slot = in_slot;
    assign pal_req.wr_rgb  = in_rgb;
    assign pal_req.rd_en   = pix_acc;
    assign pal_req.rd_slot = use_bg ? bg_slot_reg : in_code;

    gfc_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (pal_req),
        .rd_rgb (pal_rgb)
    );

    assign walk_ctl.step       = pix_acc;
    assign walk_ctl.first      = in_first;
    assign walk_ctl.interlaced = interlaced_reg;

    gfc_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (walk_ctl),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .column       (walk_col),
        .row          (walk_row)
    );

    // stage one waits on the palette read
    always_comb
    begin
        st1_valid_next = st1_valid_reg;
        if (s_tready)
        begin
            st1_valid_next = pix_acc && !skip;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_ld)
        begin
            m_valid_next = st1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            st1_row_reg <= SCREEN_BITS'(frame_top_reg) + SCREEN_BITS'(walk_row);
            st1_col_reg <= SCREEN_BITS'(frame_left_reg) + SCREEN_BITS'(walk_col);
        end
        if (out_ld && st1_valid_reg)
        begin
            m_data_reg <= {6'b0, argb, st1_col_reg, st1_row_reg};
        end
    end

    assign argb = {ALPHA_OPAQUE, pal_rgb[7:0], pal_rgb[15:8], pal_rgb[23:16]};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> sv/gfc_checker.sv
// ----------------------------------------------------------------------------
// gfc_checker
// port-level checks of the gif frame pixel compositor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gif_frame_pixel_compositor_assert.svh"

module gfc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic [gfc_pkg::OUT_DATA_BITS-1:0] m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic                              cfg_ready
);
    import gfc_pkg::*;

    // stalled output item holds
    `GFC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every drawn pixel is opaque with clear padding
    `GFC_ASSERT_IMPLY(a_opaque, clk, rst_n, m_tvalid, (m_tdata[65:58] == ALPHA_OPAQUE) && (m_tdata[71:66] == 6'b0))

    // empty output register never blocks the input
    `GFC_ASSERT_IMPLY(a_no_block, clk, rst_n, !m_tvalid, s_tready)

    // config writes always taken
    `GFC_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind gif_frame_pixel_compositor gfc_checker u_gfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready)
);

>>> bench/gif_frame_pixel_compositor_checker.sv
// ----------------------------------------------------------------------------
// gif frame pixel compositor checker
// watches the config, pixel and result channels, predicts every drawn pixel
// from its own palette and frame walk, and compares results in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gif_frame_pixel_compositor_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [gfc_pkg::IN_DATA_BITS-1:0]       s_tdata,
    input  logic                                   s_tuser,
    input  logic                                   s_tvalid,
    input  logic                                   s_tready,
    input  logic [gfc_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  gfc_pkg::cfg_idx_t                      cfg_index,
    input  logic [gfc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    output int                                     mismatch_count,
    output int                                     results_pending
);

    import gfc_pkg::*;

    localparam int   REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] argb;
        logic [16:0] col;
        logic [16:0] row;
    } drawn_pixel_t;

    drawn_pixel_t drawn_pixels [$];
    logic [23:0]  palette_rgb [256];

    logic [15:0]  walk_col;
    logic [15:0]  walk_row;
    logic [1:0]   walk_pass;

    logic [15:0]  frame_left;
    logic [15:0]  frame_top;
    logic [15:0]  frame_width;
    logic [15:0]  frame_height;
    logic         interlaced;
    trans_mode_t  trans_mode;
    logic [7:0]   trans_code;
    logic [7:0]   bg_slot;

    int           mismatches;
    drawn_pixel_t want;
    drawn_pixel_t got;

    function automatic logic [4:0] pass_step(input logic [1:0] pass);
        case (pass)
            2'd0, 2'd1: return 5'd8;
            2'd2:       return 5'd4;
            default:    return 5'd2;
        endcase
    endfunction

    function automatic logic [15:0] pass_start(input logic [1:0] pass);
        case (pass)
            2'd0:    return 16'd0;
            2'd1:    return 16'd4;
            2'd2:    return 16'd2;
            default: return 16'd1;
        endcase
    endfunction

    task automatic next_row();
        logic [16:0] nxt;
        logic        done;
        if (!interlaced) begin
            nxt = {1'b0, walk_row} + 17'd1;
            walk_row = (nxt >= {1'b0, frame_height}) ? 16'd0 : nxt[15:0];
        end
        else begin
            nxt = {1'b0, walk_row} + {12'd0, pass_step(walk_pass)};
            if (nxt < {1'b0, frame_height})
                walk_row = nxt[15:0];
            else begin
                done = 1'b0;
                while (!done) begin
                    if (walk_pass == 2'd3) begin
                        walk_pass = 2'd0;
                        walk_row  = 16'd0;
                        done      = 1'b1;
                    end
                    else begin
                        walk_pass = walk_pass + 2'd1;
                        if (pass_start(walk_pass) < frame_height) begin
                            walk_row = pass_start(walk_pass);
                            done     = 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    task automatic composite_item(input logic kind, input logic [IN_DATA_BITS-1:0] d);
        logic [7:0]   slot;
        logic [23:0]  rgb;
        logic [7:0]   code;
        logic         first;
        logic [23:0]  colour;
        logic         skip;
        drawn_pixel_t px;
        slot  = d[7:0];
        rgb   = d[31:8];
        code  = d[39:32];
        first = d[40];
        if (kind == KIND_PALETTE) begin
            palette_rgb[slot] = rgb;
            return;
        end
        if (first) begin
            walk_col  = 16'd0;
            walk_row  = 16'd0;
            walk_pass = 2'd0;
        end
        skip   = 1'b0;
        colour = 24'd0;
        if (trans_mode != TM_NONE && code == trans_code) begin
            if (trans_mode == TM_BACKGROUND)
                colour = palette_rgb[bg_slot];
            else
                skip = 1'b1;
        end
        else
            colour = palette_rgb[code];
        if (!skip) begin
            px.row  = {1'b0, frame_top} + {1'b0, walk_row};
            px.col  = {1'b0, frame_left} + {1'b0, walk_col};
            px.argb = {8'hFF, colour[7:0], colour[15:8], colour[23:16]};
            drawn_pixels.push_back(px);
        end
        if ({1'b0, walk_col} + 17'd1 >= {1'b0, frame_width}) begin
            walk_col = 16'd0;
            next_row();
        end
        else
            walk_col = walk_col + 16'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            walk_col     = 16'd0;
            walk_row     = 16'd0;
            walk_pass    = 2'd0;
            frame_left   = 16'd0;
            frame_top    = 16'd0;
            frame_width  = 16'd1;
            frame_height = 16'd1;
            interlaced   = 1'b0;
            trans_mode   = TM_NONE;
            trans_code   = 8'd0;
            bg_slot      = 8'd0;
            mismatches   = 0;
            drawn_pixels.delete();
            mismatch_count  <= 0;
            results_pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_LEFT:       frame_left   = cfg_data;
                    REG_FRAME_TOP:        frame_top    = cfg_data;
                    REG_FRAME_WIDTH:
                        frame_width  = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                    REG_FRAME_HEIGHT:
                        frame_height = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                    REG_INTERLACED:       interlaced   = cfg_data[0];
                    REG_TRANSPARENT_MODE: trans_mode   = cfg_data[1:0];
                    REG_TRANSPARENT_CODE: trans_code   = cfg_data[7:0];
                    REG_BACKGROUND_SLOT:  bg_slot      = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                composite_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata[65:0];
                if (drawn_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected pixel: row %0d col %0d argb %08h",
                                 got.row, got.col, got.argb);
                end
                else begin
                    want = drawn_pixels.pop_front();
                    if (got.row !== want.row || got.col !== want.col
                        || got.argb !== want.argb) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"pixel mismatch: row %0d/%0d col %0d/%0d",
                                      " argb %08h/%08h (exp/got)"},
                                     want.row, got.row, want.col, got.col,
                                     want.argb, got.argb);
                    end
                end
            end
            mismatch_count  <= mismatches;
            results_pending <= drawn_pixels.size();
        end
    end

endmodule

>>> bench/tb_gif_frame_pixel_compositor.sv
// ----------------------------------------------------------------------------
// gif frame pixel compositor testbench
// drives palette writes, pixel codes and register settings with random
// idling and output stalls; a side checker predicts and compares each pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gif_frame_pixel_compositor;

    import gfc_pkg::*;

    localparam trans_mode_t TM_SKIP        = 2'd2;
    localparam trans_mode_t TM_SKIP_ALT    = 2'd3;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_ITEMS   = 650;

    logic                     clk;
    logic                     rst_n;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    cfg_idx_t                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    int                       mismatch_count;
    int                       results_pending;

    bit                       slot_written [256];
    logic [7:0]               written_slots [$];
    trans_mode_t              cur_mode;
    logic [7:0]               cur_tcode;
    longint                   frame_pixels;
    longint                   px_left_in_frame;
    int                       items_sent;
    int                       send_idle;
    int                       recv_stall;
    int                       idle_cycles;

    gif_frame_pixel_compositor dut (.*);

    gif_frame_pixel_compositor_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] any_written_slot();
        return written_slots[$urandom_range(written_slots.size() - 1)];
    endfunction

    // code whose palette read, if any, hits a written entry
    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        if (cur_mode != TM_NONE && $urandom_range(3) == 0)
            c = cur_tcode;
        else
            c = 8'($urandom);
        if (!(cur_mode != TM_NONE && c == cur_tcode) && !slot_written[c])
            c = any_written_slot();
        return c;
    endfunction

    function automatic logic [15:0] coord_pick();
        logic [15:0] v;
        int          r;
        r = $urandom_range(5);
        v = 16'($urandom);
        if (r == 0)
            v = 16'd0;
        else if (r == 1)
            v = 16'hFFFF;
        return v;
    endfunction

    function automatic logic [15:0] size_pick();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(1, 12));
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] slot, input logic [23:0] rgb,
                             input logic [7:0] code, input logic first);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tdata  <= {7'd0, first, code, rgb, slot};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (kind == KIND_PALETTE && !slot_written[slot]) begin
            slot_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
    endtask

    task automatic write_palette(input logic [7:0] slot, input logic [23:0] rgb);
        send_item(KIND_PALETTE, slot, rgb, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_pixel(input logic [7:0] code, input logic first);
        send_item(KIND_PIXEL, 8'($urandom), 24'($urandom), code, first);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] left_col, input logic [15:0] top_row,
                                 input logic [15:0] width, input logic [15:0] height,
                                 input logic ilace, input trans_mode_t mode,
                                 input logic [7:0] tcode, input logic [7:0] bg);
        wait_drained();
        // skipped pixels leave no result behind, so let the pipeline empty
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_FRAME_LEFT, left_col);
        write_reg(REG_FRAME_TOP, top_row);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        write_reg(REG_INTERLACED, {15'd0, ilace});
        write_reg(REG_TRANSPARENT_MODE, {14'd0, mode});
        write_reg(REG_TRANSPARENT_CODE, {8'd0, tcode});
        write_reg(REG_BACKGROUND_SLOT, {8'd0, bg});
        cfg_valid <= 1'b0;
        cur_mode  = mode;
        cur_tcode = tcode;
        frame_pixels = longint'((width == 16'd0) ? 16'd1 : width)
                     * longint'((height == 16'd0) ? 16'd1 : height);
        px_left_in_frame = 0;
    endtask

    initial
    begin
        int          target;
        int          n_items;
        logic        first;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  tcode;
        rst_n       = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tvalid    = 1'b0;
        m_tready    = 1'b0;
        cfg_index   = REG_FRAME_LEFT;
        cfg_data    = '0;
        cfg_valid   = 1'b0;
        cur_mode    = TM_NONE;
        cur_tcode   = 8'd0;
        items_sent  = 0;
        send_idle   = 0;
        recv_stall  = 0;
        idle_cycles = 0;
        frame_pixels     = 1;
        px_left_in_frame = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: palette extremes, default one-pixel frame
        write_palette(8'h00, 24'h000000);
        write_palette(8'hFF, 24'hFFFFFF);
        write_palette(8'h5A, 24'h123456);
        write_palette(8'hA5, 24'hEDCBA9);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'hA5, 1'b1);

        // far corner, zero size, match drawn in background colour
        apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0, TM_BACKGROUND, 8'hFF, 8'h5A);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);

        // largest frame, interlaced, match skipped
        apply_setting(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, TM_SKIP, 8'h00, 8'hFF);
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);

        // small interlaced frame through all passes and past its end
        apply_setting(16'd3, 16'd7, 16'd2, 16'd5, 1'b1, TM_SKIP_ALT, 8'hA5, 8'h00);
        for (int i = 0; i < 12; i++)
            send_pixel((i % 3 == 1) ? 8'hA5 : 8'h5A, i == 0);

        target = items_sent + RANDOM_ITEMS;
        for (int ph = 0; items_sent < target; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 46; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 46; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            w = size_pick();
            h = size_pick();
            tcode = ($urandom_range(1) == 0) ? any_written_slot() : 8'($urandom);
            apply_setting(coord_pick(), coord_pick(), w, h, 1'($urandom),
                          trans_mode_t'($urandom_range(3)), tcode, any_written_slot());
            n_items = $urandom_range(50, 90);
            for (int i = 0; i < n_items; i++) begin
                if (ph == 2 && i == 30)
                    wait_drained();
                if ($urandom_range(99) < 12)
                    write_palette(8'($urandom), 24'($urandom));
                else begin
                    first = 1'b0;
                    if (px_left_in_frame == 0) begin
                        // now and then a frame runs on without a restart
                        first = ($urandom_range(9) != 0);
                        px_left_in_frame = frame_pixels;
                    end
                    else if ($urandom_range(49) == 0) begin
                        first = 1'b1;
                        px_left_in_frame = frame_pixels;
                    end
                    px_left_in_frame--;
                    send_pixel(pick_code(), first);
                end
            end
        end

        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
